>>> rtl/core/fcm_pkg.sv
// fcm_pkg: shared types and constants for the freshness counter manager.
// No dependencies; used by every module in rtl/core.

package fcm_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned CfgW   = 32;

  localparam logic [1:0] ACT_TX     = 2'd0;
  localparam logic [1:0] ACT_CHECK  = 2'd1;
  localparam logic [1:0] ACT_ACCEPT = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic CFG_TRUNC_BITS = 1'b0;
  localparam logic CFG_WINDOW     = 1'b1;

  localparam logic [BitsW-1:0]  TRUNC_BITS_RESET = 6'd32;
  localparam logic [ValueW-1:0] WINDOW_RESET     = 32'd1024;
  localparam logic [BitsW-1:0]  FULL_BITS        = 6'd32;

  typedef struct packed {
    logic [1:0]        action;
    logic [ValueW-1:0] wire_value;
    logic [ValueW-1:0] accepted_value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] full_value;
  } rsp_t;

  typedef struct packed {
    logic [ValueW-1:0] tx_count;
    logic [ValueW-1:0] rx_mark;
    logic              rx_synced;
  } state_t;

endpackage

>>> rtl/core/fcm_in_stage.sv
// fcm_in_stage: input register holding one request beat ahead of the core.
// Depends on fcm_pkg.

module fcm_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fcm_pkg::req_t req,
  input  logic          advance,
  output logic          hold_valid,
  output fcm_pkg::req_t hold
);

  assign req_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

endmodule

>>> rtl/core/fcm_core.sv
// fcm_core: configuration registers, counter state and the per-beat action logic.
// Depends on fcm_pkg.

module fcm_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fcm_pkg::CfgW-1:0]    cfg_data,
  input  logic                        fire,
  input  fcm_pkg::req_t               item,
  output fcm_pkg::rsp_t               result,
  output fcm_pkg::state_t             st
);

  logic [fcm_pkg::BitsW-1:0]  trunc_bits;
  logic [fcm_pkg::ValueW-1:0] window;
  logic [fcm_pkg::ValueW-1:0] tx_count, tx_count_next;
  logic [fcm_pkg::ValueW-1:0] rx_mark, rx_mark_next;
  logic                       rx_synced, rx_synced_next;

  logic [fcm_pkg::ValueW-1:0] mask, period, low, splice, stepped, cand, diff;
  logic                       bits_bad, bits_full, wraps, chk_ok;
  logic [fcm_pkg::ValueW-1:0] chk_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_bits <= fcm_pkg::TRUNC_BITS_RESET;
      window     <= fcm_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcm_pkg::CFG_TRUNC_BITS: trunc_bits <= cfg_data[fcm_pkg::BitsW-1:0];
        fcm_pkg::CFG_WINDOW:     window     <= cfg_data[fcm_pkg::ValueW-1:0];
        default: ;
      endcase
    end
  end

  // rebuild of the full value from the truncated wire bits
  always_comb begin
    bits_bad  = (trunc_bits == '0) || (trunc_bits > fcm_pkg::FULL_BITS);
    bits_full = (trunc_bits == fcm_pkg::FULL_BITS);
    mask      = ~({fcm_pkg::ValueW{1'b1}} << trunc_bits[4:0]);
    period    = mask + 32'd1;
    low       = item.wire_value & mask;
    splice    = (rx_mark & ~mask) | low;
    stepped   = splice + period;
    wraps     = 1'b0;
    if (bits_full) begin
      cand = item.wire_value;
    end else if (splice <= rx_mark) begin
      cand  = stepped;
      wraps = splice > ~period;
    end else begin
      cand = splice;
    end
    diff = cand - rx_mark;
    if (bits_bad) begin
      chk_ok = 1'b0;
    end else if (!rx_synced) begin
      chk_ok = 1'b1;
    end else begin
      chk_ok = !wraps && (cand > rx_mark) && (diff <= window);
    end
    chk_value = chk_ok ? (rx_synced ? cand : (bits_full ? item.wire_value : low)) : '0;
  end

  always_comb begin
    tx_count_next  = tx_count;
    rx_mark_next   = rx_mark;
    rx_synced_next = rx_synced;
    result.ok         = 1'b1;
    result.full_value = '0;
    case (item.action)
      fcm_pkg::ACT_TX: begin
        tx_count_next     = tx_count + 32'd1;
        result.full_value = tx_count_next;
      end
      fcm_pkg::ACT_CHECK: begin
        result.ok         = chk_ok;
        result.full_value = chk_value;
      end
      fcm_pkg::ACT_ACCEPT: begin
        if (!rx_synced || item.accepted_value > rx_mark) begin
          rx_mark_next   = item.accepted_value;
          rx_synced_next = 1'b1;
        end
        result.full_value = rx_mark_next;
      end
      default: begin
        tx_count_next  = '0;
        rx_mark_next   = '0;
        rx_synced_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_count  <= '0;
      rx_mark   <= '0;
      rx_synced <= 1'b0;
    end else if (fire) begin
      tx_count  <= tx_count_next;
      rx_mark   <= rx_mark_next;
      rx_synced <= rx_synced_next;
    end
  end

  assign st.tx_count  = tx_count;
  assign st.rx_mark   = rx_mark;
  assign st.rx_synced = rx_synced;

endmodule

>>> rtl/core/fcm_out_stage.sv
// fcm_out_stage: result register toward the response channel.
// Depends on fcm_pkg.

module fcm_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  fcm_pkg::rsp_t result,
  output logic          can_load,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fcm_pkg::rsp_t rsp
);

  assign can_load = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rsp <= result;
    end
  end

endmodule

>>> rtl/core/freshness_counter_manager.sv
// freshness_counter_manager: top level of the freshness value manager.
// Depends on fcm_pkg, fcm_in_stage, fcm_core, fcm_out_stage.
//
//   channel | signals                      | beat
//   req     | req_valid, req_stall, req    | action, wire_value, accepted_value
//   rsp     | rsp_valid, rsp_stall, rsp    | ok, full_value
//   cfg     | cfg_we, cfg_index, cfg_data  | one register write per enabled edge
//
// One beat per cycle unless rsp stalls; a beat is held in u_in, then in u_out.
// The action is evaluated as the beat leaves the input register, set by one
// splice, add and compare path in fcm_core.
// rst is synchronous and restores registers and counters to their reset values.
// A stalled rsp holds the result register; req stalls only when the input
// register is full and cannot move on.

module freshness_counter_manager (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  fcm_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output fcm_pkg::rsp_t            rsp,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [fcm_pkg::CfgW-1:0] cfg_data
);

  logic            hold_valid, can_load, advance;
  fcm_pkg::req_t   hold;
  fcm_pkg::rsp_t   result;
  fcm_pkg::state_t st;

  assign advance = hold_valid && can_load;

  fcm_in_stage u_in (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .advance(advance), .hold_valid(hold_valid), .hold(hold)
  );

  fcm_core u_core (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fire(advance), .item(hold), .result(result), .st(st)
  );

  fcm_out_stage u_out (
    .clk(clk), .rst(rst),
    .load(advance), .result(result), .can_load(can_load),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.full_value == '0)
    else $error("rejected check carries a nonzero value");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && hold.action == fcm_pkg::ACT_CLEAR |=>
      st.tx_count == '0 && st.rx_mark == '0 && !st.rx_synced)
    else $error("clear left state behind");

  a_accept_sync: assert property (@(posedge clk) disable iff (rst)
    advance && hold.action == fcm_pkg::ACT_ACCEPT |=> st.rx_synced)
    else $error("accept did not set sync");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> hold_valid && !can_load)
    else $error("request stalled with room to move");

endmodule
